@@ design/u8sd_pkg.sv @@
package u8sd_pkg;

    localparam int CP_W    = 21;
    localparam int LEN_W   = 3;
    localparam int ST_W    = 2;
    localparam int TOTAL_W = 16;
    localparam int PAY_W   = 7;
    localparam int CLS_W   = 3;
    localparam int QDEPTH  = 4;

    // byte classes
    localparam logic [CLS_W-1:0] CLS_ASCII = 3'd0;
    localparam logic [CLS_W-1:0] CLS_LEAD2 = 3'd1;
    localparam logic [CLS_W-1:0] CLS_LEAD3 = 3'd2;
    localparam logic [CLS_W-1:0] CLS_LEAD4 = 3'd3;
    localparam logic [CLS_W-1:0] CLS_CONT  = 3'd4;
    localparam logic [CLS_W-1:0] CLS_BAD   = 3'd5;

    // result status
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_LEAD = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_CONT = 2'd2;
    localparam logic [ST_W-1:0] ST_TRUNC    = 2'd3;

    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic [PAY_W-1:0] payload;
        logic             last;
    } entry_t;

    typedef struct packed {
        logic [CP_W-1:0]    codepoint;
        logic [LEN_W-1:0]   seq_len;
        logic [ST_W-1:0]    status;
        logic [TOTAL_W-1:0] char_total;
        logic               done;
    } result_t;

endpackage

@@ design/u8sd_front.sv @@
module u8sd_front (
    input  logic [7:0]       byte_in,
    input  logic             last_in,
    output u8sd_pkg::entry_t entry
);

    always_comb begin
        entry.last    = last_in;
        entry.payload = byte_in[6:0];
        entry.cls     = u8sd_pkg::CLS_BAD;
        if (byte_in[7] == 1'b0) begin
            entry.cls = u8sd_pkg::CLS_ASCII;
        end else if (byte_in[7:6] == 2'b10) begin
            entry.cls     = u8sd_pkg::CLS_CONT;
            entry.payload = {1'b0, byte_in[5:0]};
        end else if (byte_in[7:5] == 3'b110) begin
            entry.cls     = u8sd_pkg::CLS_LEAD2;
            entry.payload = {2'b00, byte_in[4:0]};
        end else if (byte_in[7:4] == 4'b1110) begin
            entry.cls     = u8sd_pkg::CLS_LEAD3;
            entry.payload = {3'b000, byte_in[3:0]};
        end else if (byte_in[7:3] == 5'b11110) begin
            entry.cls     = u8sd_pkg::CLS_LEAD4;
            entry.payload = {4'b0000, byte_in[2:0]};
        end
    end

endmodule

@@ design/u8sd_queue.sv @@
module u8sd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  u8sd_pkg::entry_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output u8sd_pkg::entry_t pop_data
);

    localparam int DEPTH = u8sd_pkg::QDEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    u8sd_pkg::entry_t slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != CW'(DEPTH) && cnt_reg != '0) |-> wr_ptr_reg != rd_ptr_reg)
        else $error("queue pointers out of step with count");

endmodule

@@ design/u8sd_back.sv @@
module u8sd_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  u8sd_pkg::entry_t  in_entry,
    output logic              in_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output u8sd_pkg::result_t out_result
);

    localparam int CPW = u8sd_pkg::CP_W;
    localparam int TW  = u8sd_pkg::TOTAL_W;
    localparam int LW  = u8sd_pkg::LEN_W;

    logic [1:0]             pending_reg, pending_next;
    logic [CPW-1:0]         partial_reg, partial_next;
    logic [LW-1:0]          seq_reg, seq_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [CPW-1:0]         shifted;
    logic                   valid_reg, valid_next;
    u8sd_pkg::result_t      res_reg, res_next;
    logic                   adv, emit;

    assign adv       = in_valid && (!valid_reg || out_ready);
    assign in_pop    = adv;
    assign cnt_inc   = (cnt_reg != '1) ? cnt_reg + 1'b1 : cnt_reg;
    assign shifted   = {partial_reg[CPW-7:0], in_entry.payload[5:0]};
    assign out_valid = valid_reg;
    assign out_result = res_reg;

    always_comb begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        seq_next     = seq_reg;
        cnt_next     = cnt_reg;
        emit         = 1'b0;
        res_next     = res_reg;
        res_next.done = in_entry.last;
        if (adv) begin
            if (pending_reg == 2'd0) begin
                case (in_entry.cls)
                    u8sd_pkg::CLS_ASCII: begin
                        emit     = 1'b1;
                        cnt_next = cnt_inc;
                        res_next.codepoint = CPW'(in_entry.payload);
                        res_next.seq_len   = LW'(1);
                        res_next.status    = u8sd_pkg::ST_OK;
                        res_next.char_total = TW'(cnt_inc);
                    end
                    u8sd_pkg::CLS_LEAD2: begin
                        partial_next = CPW'(in_entry.payload);
                        pending_next = 2'd1;
                        seq_next     = LW'(2);
                    end
                    u8sd_pkg::CLS_LEAD3: begin
                        partial_next = CPW'(in_entry.payload);
                        pending_next = 2'd2;
                        seq_next     = LW'(3);
                    end
                    u8sd_pkg::CLS_LEAD4: begin
                        partial_next = CPW'(in_entry.payload);
                        pending_next = 2'd3;
                        seq_next     = LW'(4);
                    end
                    default: begin
                        emit = 1'b1;
                        res_next.codepoint  = '0;
                        res_next.seq_len    = '0;
                        res_next.status     = u8sd_pkg::ST_BAD_LEAD;
                        res_next.char_total = TW'(cnt_reg);
                    end
                endcase
            end else if (in_entry.cls == u8sd_pkg::CLS_CONT) begin
                pending_next = pending_reg - 2'd1;
                partial_next = shifted;
                if (pending_reg == 2'd1) begin
                    emit         = 1'b1;
                    cnt_next     = cnt_inc;
                    res_next.codepoint  = shifted;
                    res_next.seq_len    = seq_reg;
                    res_next.status     = u8sd_pkg::ST_OK;
                    res_next.char_total = TW'(cnt_inc);
                    partial_next = '0;
                    seq_next     = '0;
                end
            end else begin
                emit         = 1'b1;
                pending_next = 2'd0;
                partial_next = '0;
                seq_next     = '0;
                res_next.codepoint  = '0;
                res_next.seq_len    = '0;
                res_next.status     = u8sd_pkg::ST_BAD_CONT;
                res_next.char_total = TW'(cnt_reg);
            end
            if (in_entry.last) begin
                if (!emit) begin
                    emit = 1'b1;
                    res_next.codepoint  = '0;
                    res_next.seq_len    = '0;
                    res_next.status     = u8sd_pkg::ST_TRUNC;
                    res_next.char_total = TW'(cnt_reg);
                end
                pending_next = 2'd0;
                partial_next = '0;
                seq_next     = '0;
                cnt_next     = '0;
            end
        end
        if (adv && emit) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            partial_reg <= '0;
            seq_reg     <= '0;
            cnt_reg     <= '0;
            valid_reg   <= 1'b0;
        end else begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            seq_reg     <= seq_next;
            cnt_reg     <= cnt_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && emit) begin
            res_reg <= res_next;
        end
    end

    a_seq_track: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 2'd0 |-> seq_reg > LW'(pending_reg))
        else $error("sequence length out of step with pending count");

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg == 2'd0 |-> (partial_reg == '0 && seq_reg == '0))
        else $error("stale partial code with no sequence open");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && res_reg.status != u8sd_pkg::ST_OK)
            |-> (res_reg.codepoint == '0 && res_reg.seq_len == '0))
        else $error("error beat carries a code point");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_entry.last) |=> (pending_reg == 2'd0 && cnt_reg == '0))
        else $error("state not cleared after last byte");

endmodule

@@ design/utf8_stream_decoder_core.sv @@
// UTF-8 stream decoder.
// Slave side: one byte per beat on s_tdata, s_tlast set on the final byte
// of a string. Master side: one beat per finished character, per bad byte,
// and always one for a byte that carries s_tlast (string truncated if a
// sequence was open). Lead bytes and inner continuation bytes give no beat.
// m_tuser carries the status: 0 ok, 1 bad lead, 2 bad continuation,
// 3 truncated. m_tlast marks the beat of the final byte of a string.
// Throughput is one byte per cycle unless low m_tready holds a beat: the
// classifier feeds a four-entry queue and the decode stage takes one queue
// entry per cycle into the output register, which holds the result beat.
// When m_tready is low the output register holds its beat, the decode stage
// stops, the queue fills and s_tready drops once four bytes are waiting.
// Reset clears the queue, the sequence state, the character count and the
// output valid. The character count saturates at 2^COUNT_WIDTH-1 and its
// low 16 bits are shown; it is cleared after each last byte.
module utf8_stream_decoder_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [20:0] codepoint, [23:21] seq_len, [39:24] char_total
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    u8sd_pkg::entry_t  front_entry;
    u8sd_pkg::entry_t  q_entry;
    u8sd_pkg::result_t result;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;

    u8sd_front u_front (
        .byte_in (s_tdata),
        .last_in (s_tlast),
        .entry   (front_entry)
    );

    u8sd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_data (front_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_entry)
    );

    u8sd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (q_valid),
        .in_entry   (q_entry),
        .in_pop     (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign s_tready = !q_full;
    assign m_tdata  = {result.char_total, result.seq_len, result.codepoint};
    assign m_tuser  = result.status;
    assign m_tlast  = result.done;

endmodule
